/* hw/rtl/cht_pkg.sv */
// Shared types and constants for the chained hash table.
// No dependencies; every other file of the block but cht_ram imports this package.
package cht_pkg;

  // Fixed field widths of the channels and the configuration register.
  localparam int KEY_IN_BITS      = 32;
  localparam int BUCKET_OUT_BITS  = 8;
  localparam int CFG_BITS         = 9;
  localparam int APB_DATA_BITS    = 32;
  localparam int APB_ADDR_BITS    = 2;
  localparam int TABLE_SIZE_RESET = 251;

  // Register indexes of the configuration port.
  localparam int REG_TABLE_SIZE = 0;

  // Bits per hash digit and the widest word of the use map.
  localparam int DIGIT_BITS     = 4;
  localparam int USED_WORD_MAX  = 32;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_DELETE = 2'd2
  } cht_func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } cht_status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_RD_USED,
    S_SCAN,
    S_ALLOC,
    S_RD_HEAD,
    S_HEAD,
    S_SET_HEAD,
    S_RD_NODE,
    S_NODE,
    S_FREE,
    S_RES_OK,
    S_RES_MISS,
    S_RES_FULL
  } cht_state_t;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_DIV,
    OP_SCAN,
    OP_ALLOC,
    OP_HEAD,
    OP_SET_HEAD_N,
    OP_STEP,
    OP_LINK_TAIL,
    OP_UNLINK,
    OP_FREE,
    OP_RES
  } cht_op_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    cht_op_t     op;
    cht_status_t status;
  } cht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       clr_done;
    logic       div_last;
    logic       pool_full;
    logic [1:0] func;
    logic       head_nil;
    logic       link_nil;
    logic       key_match;
    logic       scan_found;
    logic       out_free;
  } cht_stat_t;

endpackage

/* hw/rtl/cht_if.sv */
// Valid/ready channel interfaces for requests and results of the hash table.
// Depends on cht_pkg for the fixed field widths.
interface cht_req_if;
  import cht_pkg::*;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      func;
  logic signed [KEY_IN_BITS-1:0]   key;
  modport source (output valid, output func, output key, input ready);
  modport sink (input valid, input func, input key, output ready);
endinterface

interface cht_rsp_if;
  import cht_pkg::*;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [BUCKET_OUT_BITS-1:0]       bucket;
  logic signed [KEY_IN_BITS-1:0]    removed_key;
  modport source (output valid, output status, output bucket, output removed_key,
                  input ready);
  modport sink (input valid, input status, input bucket, input removed_key,
                output ready);
endinterface

/* hw/rtl/cht_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when we is high, read every cycle; a read of the address being written sees old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/cht_datapath.sv */
// Datapath of the hash table: hash divider, bucket/node/use-map memories,
// chain pointers and the result register. Uses cht_pkg and cht_ram.
module cht_datapath #(
  parameter int NUM_BUCKETS  = 256,
  parameter int POOL_ENTRIES = 256,
  parameter int KEY_BITS     = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  cht_pkg::cht_cmd_t                      cmd,
  output cht_pkg::cht_stat_t                     stat,
  input  logic [cht_pkg::CFG_BITS-1:0]           table_size,
  input  logic [1:0]                             in_func,
  input  logic signed [cht_pkg::KEY_IN_BITS-1:0] in_key,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic [1:0]                             out_status,
  output logic [cht_pkg::BUCKET_OUT_BITS-1:0]    out_bucket,
  output logic signed [cht_pkg::KEY_IN_BITS-1:0] out_removed_key
);
  import cht_pkg::*;

  localparam int NW        = $clog2(POOL_ENTRIES);
  localparam int PW        = $clog2(POOL_ENTRIES + 1);
  localparam int BIW       = $clog2(NUM_BUCKETS);
  localparam int DW        = $clog2(NUM_BUCKETS + 1);
  localparam int RW        = DW + 1;
  localparam int TW        = (DW > CFG_BITS) ? DW : CFG_BITS;
  localparam int MB        = ((KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS;
  localparam int DIV_STEPS = MB / DIGIT_BITS;
  localparam int SCW       = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int UW        = (POOL_ENTRIES >= USED_WORD_MAX) ? USED_WORD_MAX
                                                             : (1 << $clog2(POOL_ENTRIES));
  localparam int UBW       = $clog2(UW);
  localparam int UWORDS    = (POOL_ENTRIES + UW - 1) / UW;
  localparam int WIW       = (UWORDS > 1) ? $clog2(UWORDS) : 1;
  localparam int CLR_N     = (NUM_BUCKETS > UWORDS) ? NUM_BUCKETS : UWORDS;
  localparam int CW        = $clog2(CLR_N);
  localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

  // Control and working registers.
  logic [CW-1:0]       clr_r, clr_nxt;
  logic [SCW-1:0]      cnt_r, cnt_nxt;
  logic [MB-1:0]       mag_r, mag_nxt;
  logic [RW-1:0]       rem_r, rem_nxt;
  logic [1:0]          func_r, func_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [PW-1:0]       cur_r, cur_nxt;
  logic [PW-1:0]       prev_r, prev_nxt;
  logic [WIW-1:0]      w_r, w_nxt;
  logic [NW-1:0]       n_r, n_nxt;
  logic [PW-1:0]       count_r, count_nxt;
  logic [KEY_IN_BITS-1:0] rkey_r, rkey_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [BUCKET_OUT_BITS-1:0] bucket_r, bucket_nxt;
  logic [KEY_IN_BITS-1:0] removed_r, removed_nxt;

  // Memory ports.
  logic                head_we;
  logic [BIW-1:0]      head_waddr;
  logic [PW-1:0]       head_wdata, head_rdata;
  logic                link_we;
  logic [NW-1:0]       link_waddr;
  logic [PW-1:0]       link_wdata, link_rdata;
  logic                key_we;
  logic [KEY_BITS-1:0] key_rdata;
  logic                used_we;
  logic [WIW-1:0]      used_waddr, used_raddr;
  logic [UW-1:0]       used_wdata, used_rdata;

  // Derived values.
  logic [TW-1:0]       ts_ext;
  logic [DW-1:0]       divisor;
  logic [KEY_BITS-1:0] key_in_k;
  logic [KEY_BITS-1:0] mag_in;
  logic [RW-1:0]       div_rem;
  logic [BIW-1:0]      bucket_idx;
  logic [NW-1:0]       cur_i;
  logic [WIW-1:0]      cur_word;
  logic [UBW-1:0]      cur_bit;
  logic                scan_found;
  logic [UBW-1:0]      scan_bit;
  logic                res_ok;

  // Effective table size: zero means one bucket, large values saturate.
  assign ts_ext = TW'(table_size);
  always_comb begin
    if (ts_ext == '0) begin
      divisor = DW'(1);
    end else if (ts_ext > TW'(NUM_BUCKETS)) begin
      divisor = DW'(NUM_BUCKETS);
    end else begin
      divisor = DW'(ts_ext);
    end
  end

  // Input key in the stored width and its magnitude.
  assign key_in_k = KEY_BITS'(in_key);
  assign mag_in   = key_in_k[KEY_BITS-1] ? (~key_in_k + 1'b1) : key_in_k;

  // One radix-16 step of the restoring remainder.
  always_comb begin
    div_rem = rem_r;
    for (int i = 0; i < DIGIT_BITS; i++) begin
      div_rem = {div_rem[RW-2:0], mag_r[MB-1-i]};
      if (div_rem >= RW'(divisor)) begin
        div_rem = div_rem - RW'(divisor);
      end
    end
  end

  assign bucket_idx = rem_r[BIW-1:0];
  assign cur_i      = cur_r[NW-1:0];
  assign cur_word   = WIW'(cur_i >> UBW);
  assign cur_bit    = UBW'(cur_i);

  // Lowest free node in the use-map word being scanned.
  always_comb begin
    scan_found = 1'b0;
    scan_bit   = '0;
    for (int b = UW - 1; b >= 0; b--) begin
      if (!used_rdata[b] && (int'(w_r) * UW + b < POOL_ENTRIES)) begin
        scan_found = 1'b1;
        scan_bit   = UBW'(b);
      end
    end
  end

  // Memory write and read control.
  always_comb begin
    head_we    = 1'b0;
    head_waddr = bucket_idx;
    head_wdata = NIL;
    link_we    = 1'b0;
    link_waddr = n_r;
    link_wdata = NIL;
    key_we     = 1'b0;
    used_we    = 1'b0;
    used_waddr = w_r;
    used_wdata = used_rdata | (UW'(1) << UBW'(n_r));
    case (cmd.op)
      OP_CLEAR: begin
        head_we    = (int'(clr_r) < NUM_BUCKETS);
        head_waddr = BIW'(clr_r);
        used_we    = (int'(clr_r) < UWORDS);
        used_waddr = WIW'(clr_r);
        used_wdata = '0;
      end
      OP_ALLOC: begin
        link_we = 1'b1;
        key_we  = 1'b1;
        used_we = 1'b1;
      end
      OP_SET_HEAD_N: begin
        head_we    = 1'b1;
        head_wdata = PW'(n_r);
      end
      OP_LINK_TAIL: begin
        link_we    = 1'b1;
        link_waddr = cur_i;
        link_wdata = PW'(n_r);
      end
      OP_UNLINK: begin
        head_we    = (prev_r == NIL);
        head_wdata = link_rdata;
        link_we    = (prev_r != NIL);
        link_waddr = prev_r[NW-1:0];
        link_wdata = link_rdata;
      end
      OP_FREE: begin
        used_we    = 1'b1;
        used_waddr = cur_word;
        used_wdata = used_rdata & ~(UW'(1) << cur_bit);
      end
      default: begin
      end
    endcase
  end

  assign used_raddr = (func_r == FUNC_INSERT) ? w_r : cur_word;

  cht_ram #(.WIDTH(PW), .DEPTH(NUM_BUCKETS)) u_head_ram (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(bucket_idx), .rdata(head_rdata)
  );

  cht_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(cur_i), .rdata(link_rdata)
  );

  cht_ram #(.WIDTH(KEY_BITS), .DEPTH(POOL_ENTRIES)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(n_r), .wdata(key_r),
    .raddr(cur_i), .rdata(key_rdata)
  );

  cht_ram #(.WIDTH(UW), .DEPTH(UWORDS)) u_used_ram (
    .clk(clk), .we(used_we), .waddr(used_waddr), .wdata(used_wdata),
    .raddr(used_raddr), .rdata(used_rdata)
  );

  assign res_ok = (cmd.status == ST_OK);

  // Register updates for each operation.
  always_comb begin
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    mag_nxt       = mag_r;
    rem_nxt       = rem_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    w_nxt         = w_r;
    n_nxt         = n_r;
    count_nxt     = count_r;
    rkey_nxt      = rkey_r;
    status_nxt    = status_r;
    bucket_nxt    = bucket_r;
    removed_nxt   = removed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (cmd.op)
      OP_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
      end
      OP_LOAD: begin
        func_nxt = in_func;
        key_nxt  = key_in_k;
        mag_nxt  = MB'(mag_in);
        rem_nxt  = '0;
        cnt_nxt  = '0;
        w_nxt    = '0;
      end
      OP_DIV: begin
        rem_nxt = div_rem;
        mag_nxt = mag_r << DIGIT_BITS;
        cnt_nxt = cnt_r + 1'b1;
      end
      OP_SCAN: begin
        if (scan_found) begin
          n_nxt = NW'({w_r, scan_bit});
        end else begin
          w_nxt = w_r + 1'b1;
        end
      end
      OP_ALLOC: begin
        count_nxt = count_r + 1'b1;
      end
      OP_HEAD: begin
        cur_nxt  = head_rdata;
        prev_nxt = NIL;
      end
      OP_STEP: begin
        prev_nxt = cur_r;
        cur_nxt  = link_rdata;
      end
      OP_UNLINK: begin
        rkey_nxt = KEY_IN_BITS'($signed(key_rdata));
      end
      OP_FREE: begin
        count_nxt = count_r - 1'b1;
      end
      OP_RES: begin
        out_valid_nxt = 1'b1;
        status_nxt    = cmd.status;
        bucket_nxt    = res_ok ? BUCKET_OUT_BITS'(bucket_idx) : '0;
        removed_nxt   = (res_ok && func_r == FUNC_DELETE) ? rkey_r : '0;
      end
      default: begin
      end
    endcase
  end

  // Control state is reset; payload registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    mag_r     <= mag_nxt;
    rem_r     <= rem_nxt;
    func_r    <= func_nxt;
    key_r     <= key_nxt;
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    w_r       <= w_nxt;
    n_r       <= n_nxt;
    rkey_r    <= rkey_nxt;
    status_r  <= status_nxt;
    bucket_r  <= bucket_nxt;
    removed_r <= removed_nxt;
  end

  // Status toward the controller.
  always_comb begin
    stat.clr_done   = (clr_r == CW'(CLR_N - 1));
    stat.div_last   = (cnt_r == SCW'(DIV_STEPS - 1));
    stat.pool_full  = (count_r >= NIL);
    stat.func       = func_r;
    stat.head_nil   = (head_rdata == NIL);
    stat.link_nil   = (link_rdata == NIL);
    stat.key_match  = (key_rdata == key_r);
    stat.scan_found = scan_found;
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_bucket      = bucket_r;
  assign out_removed_key = removed_r;

endmodule

/* hw/rtl/cht_ctrl.sv */
// Controller state machine of the hash table: sequences the datapath operations.
// Uses cht_pkg for state, operation and command types.
module cht_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cht_pkg::cht_stat_t stat,
  output cht_pkg::cht_cmd_t  cmd
);
  import cht_pkg::*;

  cht_state_t state_r, state_nxt;
  logic       is_insert;
  logic       is_lookup;

  assign is_insert = (stat.func == FUNC_INSERT);
  assign is_lookup = (stat.func == FUNC_SEARCH) || (stat.func == FUNC_DELETE);

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_HASH;
      end
      S_HASH: begin
        if (stat.div_last) begin
          if (is_insert) begin
            state_nxt = stat.pool_full ? S_RES_FULL : S_RD_USED;
          end else if (is_lookup) begin
            state_nxt = S_RD_HEAD;
          end else begin
            state_nxt = S_RES_MISS;
          end
        end
      end
      S_RD_USED: state_nxt = S_SCAN;
      S_SCAN: begin
        state_nxt = stat.scan_found ? S_ALLOC : S_RD_USED;
      end
      S_ALLOC:   state_nxt = S_RD_HEAD;
      S_RD_HEAD: state_nxt = S_HEAD;
      S_HEAD: begin
        if (stat.head_nil) begin
          state_nxt = is_insert ? S_SET_HEAD : S_RES_MISS;
        end else begin
          state_nxt = S_RD_NODE;
        end
      end
      S_SET_HEAD: state_nxt = S_RES_OK;
      S_RD_NODE:  state_nxt = S_NODE;
      S_NODE: begin
        if (is_insert) begin
          state_nxt = stat.link_nil ? S_RES_OK : S_RD_NODE;
        end else if (stat.key_match) begin
          state_nxt = (stat.func == FUNC_DELETE) ? S_FREE : S_RES_OK;
        end else begin
          state_nxt = stat.link_nil ? S_RES_MISS : S_RD_NODE;
        end
      end
      S_FREE: state_nxt = S_RES_OK;
      S_RES_OK, S_RES_MISS, S_RES_FULL: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs: handshake and datapath command.
  always_comb begin
    in_ready   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.status = ST_OK;
    case (state_r)
      S_CLEAR: cmd.op = OP_CLEAR;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_HASH:     cmd.op = OP_DIV;
      S_SCAN:     cmd.op = OP_SCAN;
      S_ALLOC:    cmd.op = OP_ALLOC;
      S_HEAD:     cmd.op = OP_HEAD;
      S_SET_HEAD: cmd.op = OP_SET_HEAD_N;
      S_NODE: begin
        if (is_insert) begin
          cmd.op = stat.link_nil ? OP_LINK_TAIL : OP_STEP;
        end else if (stat.key_match) begin
          cmd.op = (stat.func == FUNC_DELETE) ? OP_UNLINK : OP_NONE;
        end else begin
          cmd.op = stat.link_nil ? OP_NONE : OP_STEP;
        end
      end
      S_FREE: cmd.op = OP_FREE;
      S_RES_OK: begin
        if (stat.out_free) cmd.op = OP_RES;
      end
      S_RES_MISS: begin
        cmd.status = ST_NOT_FOUND;
        if (stat.out_free) cmd.op = OP_RES;
      end
      S_RES_FULL: begin
        cmd.status = ST_FULL;
        if (stat.out_free) cmd.op = OP_RES;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/chained_hash_table.sv */
// Hash table with separate chaining over a bounded node pool. Each request
// inserts, searches or deletes a signed key; the bucket is the key's magnitude
// modulo table_size (zero acts as one, values above NUM_BUCKETS saturate). One
// request is in work at a time. The hash comes from a radix-16 remainder unit,
// then a chain walk reads one node at a time through the registered node
// memory. An insert also scans the use map a word (up to 32 nodes) at a time for
// the lowest free node. The controller can take the next request in the cycle
// after it loads the result register. After reset a clearing pass empties the
// bucket heads and the use map; requests wait for it.
// Depends on cht_pkg, cht_if, cht_ram, cht_datapath and cht_ctrl.
module chained_hash_table #(
  parameter int NUM_BUCKETS  = 256,
  parameter int POOL_ENTRIES = 256,
  parameter int KEY_BITS     = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  cht_req_if.sink                                 in_ch,
  cht_rsp_if.source                               out_ch,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [cht_pkg::APB_ADDR_BITS-1:0]       paddr,
  input  logic [cht_pkg::APB_DATA_BITS-1:0]       pwdata,
  output logic [cht_pkg::APB_DATA_BITS-1:0]       prdata,
  output logic                                    pready
);
  import cht_pkg::*;

  logic [CFG_BITS-1:0] table_size_r, table_size_nxt;
  logic                reg_sel;
  cht_cmd_t            cmd;
  cht_stat_t           stat;

  // Configuration register, written in the access phase of a transfer.
  assign pready  = 1'b1;
  assign reg_sel = (paddr == APB_ADDR_BITS'(REG_TABLE_SIZE * 4));
  always_comb begin
    table_size_nxt = table_size_r;
    if (psel && penable && pwrite && reg_sel) begin
      table_size_nxt = pwdata[CFG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= CFG_BITS'(TABLE_SIZE_RESET);
    end else begin
      table_size_r <= table_size_nxt;
    end
  end

  assign prdata = reg_sel ? APB_DATA_BITS'(table_size_r) : '0;

  cht_ctrl u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .stat(stat),
    .cmd(cmd)
  );

  cht_datapath #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .POOL_ENTRIES(POOL_ENTRIES),
    .KEY_BITS(KEY_BITS)
  ) u_datapath (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .stat(stat),
    .table_size(table_size_r),
    .in_func(in_ch.func),
    .in_key(in_ch.key),
    .out_ready(out_ch.ready),
    .out_valid(out_ch.valid),
    .out_status(out_ch.status),
    .out_bucket(out_ch.bucket),
    .out_removed_key(out_ch.removed_key)
  );

endmodule

/* dv/cht_checker.sv */
// Checker for the chained hash table: watches the request, result and register channels,
// keeps its own model of the table and compares every result transfer against it.
// Depends on cht_pkg and the cht_req_if / cht_rsp_if interfaces.
`timescale 1ns / 100ps

module cht_checker
  import cht_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  cht_req_if                       req,
  cht_rsp_if                       rsp,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     pready,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output int                       fail_count,
  output int                       pending
);

  localparam int BUCKETS   = 256;
  localparam int NODES     = 256;
  localparam logic [8:0] NIL = 9'd256;

  typedef struct packed {
    cht_status_t                 status;
    logic [BUCKET_OUT_BITS-1:0]  bucket;
    logic [KEY_IN_BITS-1:0]      removed_key;
  } lookup_result_t;

  // Shadow copy of the table and its configuration.
  logic [CFG_BITS-1:0]    size_reg;
  logic [8:0]             head_ptr [BUCKETS];
  logic [KEY_IN_BITS-1:0] key_mem  [NODES];
  logic [8:0]             link_mem [NODES];
  logic                   in_use   [NODES];
  int                     live_nodes;
  lookup_result_t         expected_results [$];

  assign pending = expected_results.size();

  // Computes the result of one operation and updates the shadow table.
  function automatic lookup_result_t apply_op(logic [1:0] fn, logic [KEY_IN_BITS-1:0] k);
    lookup_result_t r;
    logic [31:0] mag;
    int eff, b, cur, prev, n;
    r = '{status: ST_NOT_FOUND, bucket: '0, removed_key: '0};
    eff = (size_reg == 0) ? 1 : ((size_reg > BUCKETS) ? BUCKETS : int'(size_reg));
    mag = k[31] ? (~k + 32'd1) : k;
    b = int'(mag % 32'(eff));
    if (fn == FUNC_INSERT) begin
      r.status = ST_FULL;
      if (live_nodes < NODES) begin
        n = 0;
        while (in_use[n]) n++;
        in_use[n] = 1'b1;
        key_mem[n] = k;
        link_mem[n] = NIL;
        live_nodes++;
        if (head_ptr[b] == NIL) begin
          head_ptr[b] = 9'(n);
        end else begin
          cur = head_ptr[b];
          while (link_mem[cur] != NIL) cur = link_mem[cur];
          link_mem[cur] = 9'(n);
        end
        r.status = ST_OK;
        r.bucket = 8'(b);
      end
    end else if (fn == FUNC_SEARCH || fn == FUNC_DELETE) begin
      prev = NIL;
      cur = head_ptr[b];
      while (cur != NIL && key_mem[cur] != k) begin
        prev = cur;
        cur = link_mem[cur];
      end
      if (cur != NIL) begin
        r.status = ST_OK;
        r.bucket = 8'(b);
        if (fn == FUNC_DELETE) begin
          if (prev == NIL) head_ptr[b] = link_mem[cur];
          else link_mem[prev] = link_mem[cur];
          in_use[cur] = 1'b0;
          live_nodes--;
          r.removed_key = key_mem[cur];
        end
      end
    end
    return r;
  endfunction

  // Track register writes, request transfers and result transfers.
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst_n) begin
      size_reg <= CFG_BITS'(TABLE_SIZE_RESET);
      for (int i = 0; i < BUCKETS; i++) head_ptr[i] = NIL;
      for (int i = 0; i < NODES; i++) in_use[i] = 1'b0;
      live_nodes = 0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr == APB_ADDR_BITS'(REG_TABLE_SIZE * 4))
        size_reg <= pwdata[CFG_BITS-1:0];
      if (req.valid && req.ready)
        expected_results.push_back(apply_op(req.func, req.key));
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("%0t: unexpected result transfer status=%0d bucket=%0d removed=%0d",
                     $realtime, rsp.status, rsp.bucket, rsp.removed_key);
        end else begin
          want = expected_results.pop_front();
          if (rsp.status !== want.status || rsp.bucket !== want.bucket ||
              rsp.removed_key !== want.removed_key) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("%0t: mismatch expected %0d/%0d/%0d actual %0d/%0d/%0d", $realtime,
                       want.status, want.bucket, $signed(want.removed_key),
                       rsp.status, rsp.bucket, rsp.removed_key);
          end
        end
      end
    end
  end

endmodule

/* dv/chained_hash_table_tb.sv */
// Top of the chained hash table testbench: clock, reset, register writes and stimulus.
// Depends on cht_pkg, cht_if, the block and cht_checker.
`timescale 1ns / 100ps

module chained_hash_table_tb;
  import cht_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 300;

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata, prdata;
  int fail_count, pending, cycles;
  logic quiet, hold_req;

  cht_req_if req_ch ();
  cht_rsp_if rsp_ch ();

  chained_hash_table DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(req_ch), .out_ch(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cht_checker checker_i (
    .clk(clk), .rst_n(rst_n), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, one long hold-off on request.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic reg_write(input int idx, input logic [APB_DATA_BITS-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_BITS'(idx * 4);
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drive one request and wait for its transfer; valid stays high after it unless the next call adds a gap.
  task automatic send_op(input logic [1:0] fn, input logic [31:0] k);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= fn;
    req_ch.key <= k;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    case ($urandom_range(0, 7))
      0: k = $urandom;
      1: case ($urandom_range(0, 3))
           0: k = 32'h0000_0000;
           1: k = 32'hFFFF_FFFF;
           2: k = 32'h7FFF_FFFF;
           default: k = 32'h8000_0000;
         endcase
      default: begin
        k = $urandom_range(0, 400);
        if ($urandom_range(0, 1)) k = -k;
      end
    endcase
    return k;
  endfunction

  // Random traffic; ins_pct sets the share of inserts and unused codes together, 3 percent being unused codes.
  task automatic run_mix(input int count, input int ins_pct);
    int r;
    logic [1:0] fn;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) fn = FUNC_UNUSED;
      else if (r < ins_pct) fn = FUNC_INSERT;
      else fn = $urandom_range(0, 1) ? FUNC_SEARCH : FUNC_DELETE;
      send_op(fn, pick_key());
    end
  endtask

  initial begin
    quiet = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_INSERT;
    req_ch.key = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, duplicates, misses and the unused operation code.
    send_op(FUNC_INSERT, 32'd0);
    send_op(FUNC_INSERT, 32'h7FFF_FFFF);
    send_op(FUNC_INSERT, 32'h8000_0000);
    send_op(FUNC_INSERT, 32'hFFFF_FFFF);
    send_op(FUNC_INSERT, 32'd251);
    send_op(FUNC_INSERT, 32'd251);
    send_op(FUNC_SEARCH, 32'd251);
    send_op(FUNC_DELETE, 32'd251);
    send_op(FUNC_SEARCH, 32'd251);
    send_op(FUNC_DELETE, 32'd251);
    send_op(FUNC_SEARCH, 32'd251);
    send_op(FUNC_DELETE, 32'd251);
    send_op(FUNC_UNUSED, 32'd5);
    send_op(FUNC_SEARCH, 32'h8000_0000);
    send_op(FUNC_DELETE, 32'h7FFF_FFFF);
    send_op(FUNC_SEARCH, 32'd502);
    send_op(FUNC_SEARCH, -32'sd502);
    drain();

    // One bucket: every key shares a chain; zero size acts the same.
    reg_write(REG_TABLE_SIZE, 32'd1);
    run_mix(80, 45);
    drain();
    reg_write(REG_TABLE_SIZE, 32'd0);
    run_mix(60, 40);
    drain();

    // Size above the bucket count saturates; fill the pool past full, then run mostly searches and deletes.
    reg_write(REG_TABLE_SIZE, 32'd300);
    run_mix(280, 97);
    run_mix(300, 5);
    drain();
    reg_write(REG_TABLE_SIZE, 32'd511);
    run_mix(300, 40);
    drain();

    // Full-size table with a long result hold-off in the middle.
    reg_write(REG_TABLE_SIZE, 32'd256);
    run_mix(150, 40);
    hold_req = 1'b1;
    run_mix(250, 40);
    drain();

    for (int p = 0; p < 3; p++) begin
      reg_write(REG_TABLE_SIZE, $urandom_range(2, 255));
      if (p == 2) quiet = 1'b1;
      run_mix(200, 40);
      drain();
    end

    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
